// ===== sv/scw_pkg.sv =====
// Shared types and constants for the soft clipping waveshaper.
// Used by scw_regs, soft_clip_waveshaper_q15 and the testbench; depends on nothing else.
package scw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_WHOLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FRAC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_KNEE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_KNEE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_COEF   = 3'd6;

    // Q15 constants of the quadratic region.
    localparam int TWO_Q15   = 65536;
    localparam int THREE_Q15 = 98304;

    // Clipper regions.
    localparam logic [1:0] REGION_LIN = 2'd0;
    localparam logic [1:0] REGION_MID = 2'd1;
    localparam logic [1:0] REGION_LIM = 2'd2;

    typedef struct packed {
        logic [3:0]  gain_whole;
        logic [14:0] gain_fraction;
        logic [2:0]  headroom_shift;
        logic [14:0] prescale_factor;
        logic [14:0] low_knee;
        logic [14:0] high_knee;
        logic [14:0] third_coefficient;
    } t_cfg;

endpackage

// ===== sv/scw_regs.sv =====
// Configuration register file of the soft clipping waveshaper.
// Depends on scw_pkg for register indexes and the t_cfg struct.
module scw_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output scw_pkg::t_cfg                     o_cfg
);
    import scw_pkg::*;

    t_cfg r_cfg;

    // The port takes a word in every cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_whole        <= 4'd1;
            r_cfg.gain_fraction     <= 15'd0;
            r_cfg.headroom_shift    <= 3'd0;
            r_cfg.prescale_factor   <= 15'd21845;
            r_cfg.low_knee          <= 15'd10922;
            r_cfg.high_knee         <= 15'd21845;
            r_cfg.third_coefficient <= 15'd10922;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_WHOLE: r_cfg.gain_whole        <= i_cfg_data[3:0];
                CFG_GAIN_FRAC:  r_cfg.gain_fraction     <= i_cfg_data;
                CFG_HEADROOM:   r_cfg.headroom_shift    <= i_cfg_data[2:0];
                CFG_PRESCALE:   r_cfg.prescale_factor   <= i_cfg_data;
                CFG_LOW_KNEE:   r_cfg.low_knee          <= i_cfg_data;
                CFG_HIGH_KNEE:  r_cfg.high_knee         <= i_cfg_data;
                CFG_THIRD_COEF: r_cfg.third_coefficient <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/soft_clip_waveshaper_q15.sv =====
// A sample accepted by the block leaves with o_valid high for one cycle.
// Throughput: one sample per clock; o_busy is low whenever reset is released, so samples may
// follow each other in every cycle, and the receiver cannot stall the output.
// The rate is set by the nine-stage pipeline; stage 2 holds two multipliers, the other stages at most one.
// Reset (synchronous, active low) empties the pipeline and restores every configuration
// register to its nominal value; o_busy is high while reset is asserted.
module soft_clip_waveshaper_q15 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample input
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [15:0]                i_sample_in,
    input  logic                              i_last_in,
    // Sample output
    output logic                              o_valid,
    output logic signed [15:0]                o_sample_out,
    output logic                              o_last_out,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import scw_pkg::*;

    // Side information that travels with a sample once its region is known.
    typedef struct packed {
        logic [1:0]         region;
        logic               neg;     // sign of the gained value x
        logic               pneg;    // sign of the prescaled value p
        logic               last;
        logic signed [28:0] y_lin;   // 2*x, the linear region result
    } t_tag;

    t_cfg cfg;

    scw_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The pipeline never stalls, so a word is taken whenever reset is released.
    assign o_busy = !i_rst_n;

    logic accept;
    assign accept = i_start && !o_busy;

    // Valid bits, one per stage register r1 to r8; o_valid is registered from the last one.
    logic [7:0] r_vld;

    // Stage registers. Payload carries no reset.
    logic signed [31:0] r1_prod;
    logic               r1_last;
    logic signed [27:0] r2_vgw;
    logic signed [38:0] r2_vgf;
    logic               r2_pneg, r2_last;
    logic signed [27:0] r3_x;
    logic               r3_pneg, r3_last;
    logic [14:0]        r4_ax;
    t_tag               r4_tag, r5_tag, r6_tag, r7_tag, r8_tag;
    logic signed [17:0] r5_t;
    logic [32:0]        r6_tt;
    logic signed [18:0] r7_q;
    logic signed [34:0] r8_qc;

    // Next values of the stage registers.
    logic signed [31:0] n1_prod;
    logic signed [15:0] p;
    logic signed [22:0] v;
    logic signed [27:0] n2_vgw;
    logic signed [38:0] n2_vgf;
    logic signed [27:0] n3_x;
    logic [27:0]        ax;
    logic               in_lin, in_mid;
    t_tag               n4_tag;
    logic [16:0]        ax3;
    logic signed [17:0] n5_t;
    logic signed [35:0] tt_full;
    logic signed [18:0] q0;
    logic signed [18:0] n7_q;
    logic signed [34:0] n8_qc;
    logic signed [28:0] y, y_sh;

    always_comb begin
        // Stage 1: prescale product, 16 x 16 signed.
        n1_prod = i_sample_in * $signed({1'b0, cfg.prescale_factor});

        // Stage 2: floor by 2^15, headroom shift, then both gain products.
        // The prescaled value always fits 16 bits because the factor is below one.
        p      = r1_prod[30:15];
        v      = $signed({{7{p[15]}}, p}) <<< cfg.headroom_shift;
        n2_vgw = v * $signed({1'b0, cfg.gain_whole});
        n2_vgf = v * $signed({1'b0, cfg.gain_fraction});

        // Stage 3: whole part plus floored fractional part.
        n3_x = r2_vgw + $signed({{4{r2_vgf[38]}}, r2_vgf[38:15]});

        // Stage 4: magnitude and region decision.
        ax     = r3_x[27] ? $unsigned(-r3_x) : $unsigned(r3_x);
        in_lin = ax <= {13'd0, cfg.low_knee};
        in_mid = ax <= {13'd0, cfg.high_knee};
        n4_tag.region = in_lin ? REGION_LIN : (in_mid ? REGION_MID : REGION_LIM);
        n4_tag.neg    = r3_x[27];
        n4_tag.pneg   = r3_pneg;
        n4_tag.last   = r3_last;
        n4_tag.y_lin  = $signed({r3_x, 1'b0});

        // Stage 5: t = 2 - 3|x| in Q15. Only the middle region uses it, where |x| fits 15 bits.
        ax3  = {2'b00, r4_ax} + {1'b0, r4_ax, 1'b0};
        n5_t = $signed(18'(TWO_Q15)) - $signed({1'b0, ax3});

        // Stage 6: t squared. In the middle region |x| is at least one LSB, so the square stays below 2^32.
        tt_full = r5_t * r5_t;

        // Stage 7: q = 3 - t^2 in Q15, with the sign of x.
        q0   = $signed(19'(THREE_Q15)) - $signed({1'b0, r6_tt[32:15]});
        n7_q = r6_tag.neg ? -q0 : q0;

        // Stage 8: multiply by the third coefficient, one third at its reset value.
        n8_qc = r7_q * $signed({1'b0, cfg.third_coefficient});

        // Stage 9: pick the region result and undo the headroom shift.
        case (r8_tag.region)
            REGION_LIN: y = r8_tag.y_lin;
            REGION_MID: y = $signed({{9{r8_qc[34]}}, r8_qc[34:15]});
            REGION_LIM: y = r8_tag.pneg ? -29'sd32768 : 29'sd32767;
            default:    y = r8_tag.y_lin;
        endcase
        y_sh = y >>> cfg.headroom_shift;
    end

    // Control: valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[6:0], accept};
            o_valid <= r_vld[7];
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r1_prod      <= n1_prod;
        r1_last      <= i_last_in;
        r2_vgw       <= n2_vgw;
        r2_vgf       <= n2_vgf;
        r2_pneg      <= p[15];
        r2_last      <= r1_last;
        r3_x         <= n3_x;
        r3_pneg      <= r2_pneg;
        r3_last      <= r2_last;
        r4_ax        <= ax[14:0];
        r4_tag       <= n4_tag;
        r5_t         <= n5_t;
        r5_tag       <= r4_tag;
        r6_tt        <= tt_full[32:0];
        r6_tag       <= r5_tag;
        r7_q         <= n7_q;
        r7_tag       <= r6_tag;
        r8_qc        <= n8_qc;
        r8_tag       <= r7_tag;
        o_sample_out <= y_sh[15:0];
        o_last_out   <= r8_tag.last;
    end

    // Every output strobe comes from a sample that the pipeline took.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 9))
        else $error("output strobe without a sample taken nine cycles earlier");

    // In the middle region the square of t never reaches 2^32.
    a_square_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && r6_tag.region == REGION_MID) |-> !r6_tt[32])
        else $error("square of t overflowed its 32-bit range");

    // A linear region result is twice a value no larger than a 15-bit knee.
    a_lin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r4_tag.region == REGION_LIN) |->
            (r4_tag.y_lin >= -29'sd65534 && r4_tag.y_lin <= 29'sd65534))
        else $error("linear region value beyond twice the knee range");

endmodule

// ===== test/scw_shape_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the soft clipping waveshaper: mirrors the configuration registers,
// predicts each shaped word and compares it with the block's output strobe.
// Depends on scw_pkg for the register indexes, the Q15 constants and t_cfg.
module scw_shape_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic signed [15:0]             i_sample_in,
    input  logic                           i_last_in,
    input  logic                           i_valid,
    input  logic signed [15:0]             i_sample_out,
    input  logic                           i_last_out,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [scw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import scw_pkg::*;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_shaped_word;

    t_cfg         regs;
    t_shaped_word expected_words[$];
    int           fails = 0;
    int           word_count = 0;

    // Full-width model of the prescale, gain, three-region clipper and headroom shift.
    // Signed 64-bit arithmetic with >>> gives floor division by powers of two.
    function automatic t_shaped_word shape_sample(input logic signed [15:0] s_in,
                                                  input logic l_in);
        t_shaped_word w;
        longint s, pf, gw, gf, lk, hk, tc;
        longint p, v, x, ax, t, q, y;
        int     sh;
        s  = longint'(s_in);
        pf = longint'(regs.prescale_factor);
        gw = longint'(regs.gain_whole);
        gf = longint'(regs.gain_fraction);
        lk = longint'(regs.low_knee);
        hk = longint'(regs.high_knee);
        tc = longint'(regs.third_coefficient);
        sh = int'(regs.headroom_shift);
        p  = (s * pf) >>> 15;
        v  = p <<< sh;
        x  = v * gw + ((v * gf) >>> 15);
        ax = (x < 0) ? -x : x;
        if (ax <= lk) begin
            y = x + x;
        end else if (ax <= hk) begin
            t = longint'(TWO_Q15) - ((longint'(THREE_Q15) * ax) >>> 15);
            q = longint'(THREE_Q15) - ((t * t) >>> 15);
            if (x < 0) begin
                q = -q;
            end
            y = (q * tc) >>> 15;
        end else begin
            y = (p < 0) ? -longint'(32768) : longint'(32767);
        end
        y = y >>> sh;
        w.sample = y[15:0];
        w.last   = l_in;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        fails++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : monitor
        t_shaped_word want;
        if (!i_rst_n) begin
            regs.gain_whole        = 4'd1;
            regs.gain_fraction     = 15'd0;
            regs.headroom_shift    = 3'd0;
            regs.prescale_factor   = 15'd21845;
            regs.low_knee          = 15'd10922;
            regs.high_knee         = 15'd21845;
            regs.third_coefficient = 15'd10922;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAIN_WHOLE: regs.gain_whole        = i_cfg_data[3:0];
                    CFG_GAIN_FRAC:  regs.gain_fraction     = i_cfg_data;
                    CFG_HEADROOM:   regs.headroom_shift    = i_cfg_data[2:0];
                    CFG_PRESCALE:   regs.prescale_factor   = i_cfg_data;
                    CFG_LOW_KNEE:   regs.low_knee          = i_cfg_data;
                    CFG_HIGH_KNEE:  regs.high_knee         = i_cfg_data;
                    CFG_THIRD_COEF: regs.third_coefficient = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("word %0d with nothing expected: sample %0d last %0b",
                                              word_count, i_sample_out, i_last_out));
                end else begin
                    want = expected_words.pop_front();
                    if (i_sample_out !== want.sample) begin
                        report_mismatch($sformatf("word %0d sample_out %0d, expected %0d",
                                                  word_count, i_sample_out, want.sample));
                    end
                    if (i_last_out !== want.last) begin
                        report_mismatch($sformatf("word %0d last_out %0b, expected %0b",
                                                  word_count, i_last_out, want.last));
                    end
                end
                word_count++;
            end
            if (i_start && !i_busy) begin
                expected_words.push_back(shape_sample(i_sample_in, i_last_in));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Top of the waveshaper testbench: clock, reset, sample and register stimulus, and the verdict.
// Depends on scw_pkg, soft_clip_waveshaper_q15 and the scw_shape_checker scoreboard.
module tb;
    import scw_pkg::*;

    // No handshake of any kind for this many cycles means the block has hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 110;
    // The final phases run without idle bursts so the pipeline sees back-to-back words.
    localparam int QUIET_PHASES    = 3;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic signed [15:0]    sample_in  = '0;
    logic                  last_in    = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    wire                   busy;
    wire                   valid;
    wire signed [15:0]     sample_out;
    wire                   last_out;
    wire                   cfg_ready;
    int                    fail_count;
    int                    pending;
    int                    stall_cycles = 0;
    bit                    idling_on    = 1'b1;

    always #1 clk = ~clk;

    soft_clip_waveshaper_q15 u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_sample_in  (sample_in),
        .i_last_in    (last_in),
        .o_valid      (valid),
        .o_sample_out (sample_out),
        .o_last_out   (last_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    scw_shape_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_sample_in  (sample_in),
        .i_last_in    (last_in),
        .i_valid      (valid),
        .i_sample_out (sample_out),
        .i_last_out   (last_out),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Any accepted word on either channel, or an output strobe, counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("soft_clip_waveshaper_q15 test failed");
            $finish;
        end
    end

    // One register write. Valid stays high afterwards so back-to-back writes never drop it
    // within a time step; program_setting lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_setting(input t_cfg c);
        write_reg(CFG_GAIN_WHOLE, CFG_DATA_W'(c.gain_whole));
        write_reg(CFG_GAIN_FRAC,  c.gain_fraction);
        write_reg(CFG_HEADROOM,   CFG_DATA_W'(c.headroom_shift));
        write_reg(CFG_PRESCALE,   c.prescale_factor);
        write_reg(CFG_LOW_KNEE,   c.low_knee);
        write_reg(CFG_HIGH_KNEE,  c.high_knee);
        write_reg(CFG_THIRD_COEF, c.third_coefficient);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Presents one sample word, sometimes after an idle burst, and holds it until accepted.
    // Start is left high so consecutive words can go in on consecutive edges.
    task automatic push_sample(input int s, input logic l);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap   = $urandom_range(1, 10);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     = 1'b1;
        sample_in = 16'(s);
        last_in   = l;
        do @(posedge clk); while (busy);
    endtask

    task automatic close_burst();
        @(negedge clk);
        start = 1'b0;
    endtask

    // Every word yields exactly one result, so an empty scoreboard means an empty pipeline;
    // the extra cycles cover the nine-stage latency anyway before registers change.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic t_cfg make_setting(input int gw, input int gf, input int hs,
                                          input int pf, input int lk, input int hk,
                                          input int tc);
        t_cfg c;
        c.gain_whole        = 4'(gw);
        c.gain_fraction     = 15'(gf);
        c.headroom_shift    = 3'(hs);
        c.prescale_factor   = 15'(pf);
        c.low_knee          = 15'(lk);
        c.high_knee         = 15'(hk);
        c.third_coefficient = 15'(tc);
        return c;
    endfunction

    // Leans toward nominal values so that the quadratic region gets real traffic,
    // while both ends of every range still come up regularly.
    function automatic int pick_value(input int max_value, input int nominal);
        int v;
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = max_value;
            2, 3:    v = nominal;
            default: v = $urandom_range(0, max_value);
        endcase
        return v;
    endfunction

    function automatic t_cfg random_setting();
        t_cfg c;
        int   lo_k;
        int   hi_k;
        int   tmp;
        c.gain_whole        = 4'(pick_value(15, 1));
        c.gain_fraction     = 15'(pick_value(32767, 0));
        c.headroom_shift    = 3'(pick_value(7, $urandom_range(0, 4)));
        c.prescale_factor   = 15'(pick_value(32767, 21845));
        c.third_coefficient = 15'(pick_value(32767, 10922));
        lo_k = pick_value(32767, 10922);
        hi_k = pick_value(32767, 21845);
        // Mostly ordered knees; swapped ones leave an empty middle region.
        if (lo_k > hi_k && $urandom_range(0, 3) != 0) begin
            tmp  = lo_k;
            lo_k = hi_k;
            hi_k = tmp;
        end
        c.low_knee  = 15'(lo_k);
        c.high_knee = 15'(hi_k);
        return c;
    endfunction

    // Full-range samples, full-scale extremes, and scaled-down samples that reach the
    // linear and quadratic regions more often at large gains.
    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] r;
        r = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0:       r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3: r = r >>> $urandom_range(1, 13);
            default: ;
        endcase
        return r;
    endfunction

    initial begin : stimulus
        t_cfg setting;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Register values straight out of reset: full-scale inputs, zero, the smallest
        // magnitudes, and samples on both sides of the low knee and in the quadratic region.
        push_sample(-32768, 1'b0);
        push_sample(32767, 1'b1);
        push_sample(0, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-1, 1'b1);
        push_sample(16383, 1'b0);
        push_sample(16384, 1'b0);
        push_sample(-16384, 1'b1);
        push_sample(24000, 1'b0);
        push_sample(-24000, 1'b0);
        push_sample(32000, 1'b1);
        push_sample(-2, 1'b0);
        close_burst();
        drain();

        // Gain of 2.5 pushes full-scale inputs past the high knee into the hard limit.
        program_setting(make_setting(2, 16384, 0, 21845, 10922, 21845, 10922));
        push_sample(32767, 1'b0);
        push_sample(-32768, 1'b1);
        push_sample(12000, 1'b0);
        push_sample(-12000, 1'b0);
        push_sample(4000, 1'b1);
        close_burst();
        drain();

        // Knees out of order with a wide linear region and maximum gain: the doubled
        // value no longer fits in 16 bits and wraps.
        program_setting(make_setting(15, 32767, 0, 32767, 32767, 0, 32767));
        push_sample(1000, 1'b0);
        push_sample(2000, 1'b1);
        push_sample(-2000, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(32767, 1'b1);
        close_burst();
        drain();

        // Headroom beyond its nominal range.
        program_setting(make_setting(1, 0, 7, 21845, 10922, 21845, 10922));
        push_sample(200, 1'b0);
        push_sample(-200, 1'b1);
        push_sample(32767, 1'b0);
        close_burst();
        drain();

        // Random phases: all-zero registers, all-maximum registers, then random settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                setting = make_setting(0, 0, 0, 0, 0, 0, 0);
            end else if (ph == 1) begin
                setting = make_setting(15, 32767, 7, 32767, 32767, 32767, 32767);
            end else begin
                setting = random_setting();
            end
            idling_on = (ph < RANDOM_PHASES - QUIET_PHASES);
            program_setting(setting);
            repeat (WORDS_PER_PHASE) push_sample(int'(pick_sample()), 1'($urandom_range(0, 1)));
            close_burst();
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("soft_clip_waveshaper_q15 test passed");
        end else begin
            $display("soft_clip_waveshaper_q15 test failed");
        end
        $finish;
    end

endmodule
